// File: rtl/flight_phase_sequencer_unit_macros.svh
// Assertion macros for the flight phase sequencer.
// Both assume a clock named clk and a synchronous reset named rst in scope.
`ifndef FLIGHT_PHASE_SEQUENCER_UNIT_MACROS_SVH
`define FLIGHT_PHASE_SEQUENCER_UNIT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define FPS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fps: same-cycle check failed");
// next-cycle implication
`define FPS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fps: next-cycle check failed");
`else
`define FPS_ASSERT_IMP(lbl, ante, cons)
`define FPS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: rtl/fps_pkg.sv
`default_nettype none

package fps_pkg;

  // flight phases
  typedef enum logic [2:0] {
    PH_PAD       = 3'd0,
    PH_BOOST     = 3'd1,
    PH_STAGING   = 3'd2,
    PH_PARACHUTE = 3'd3,
    PH_GROUND    = 3'd4
  } phase_t;

  // config register indexes
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_BOOST_TRIGGER     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STAGING_TRIGGER   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MAIN_ALTITUDE_AGL = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_GROUND_LEVEL      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SEPARATION_DELAY  = 3'd4;

  localparam logic [7:0] SEP_DELAY_RESET = 8'd16;

  localparam int unsigned TICKS_W   = 4;
  localparam int unsigned TICKS_MAX = 15;
  localparam int unsigned COUNT_W   = 16;

  localparam int unsigned SAMPLE_PERIOD_DEF = 8;

  typedef struct packed {
    logic signed [15:0]   accel_axial;
    logic [15:0]          altitude;
    logic [TICKS_W-1:0]   half_ticks;
  } sample_t;

  typedef struct packed {
    logic [2:0] flight_phase;
    logic       separation_fire;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/flight_phase_sequencer_unit.sv
`default_nettype none

// Flight phase sequencer. Each sensor sample transfer (axial acceleration,
// altitude, half-seconds since the previous sample) steps the phase through
// pad, boost, staging, parachute and ground, and yields exactly one result
// transfer carrying the phase after the step and the latched separation fire.
// A sample goes into an input register, the whole step is worked out by short
// logic from that register and the state, and the result lands in an output
// register: one sample per cycle unless the result stalls; a result is valid
// once its sample has passed both registers. While a result waits under stall
// the input register still takes one more sample, then the input stalls until
// the result transfers. Users must set thresholds and the separation delay
// through the write port only while the block is idle; the block does not
// enforce this. SAMPLE_PERIOD (2..64) sets the half-second spacing of apogee
// altitude snapshots. Phase advances at most once per sample; ground is final.

`include "flight_phase_sequencer_unit_macros.svh"

module flight_phase_sequencer_unit #(
  parameter int unsigned SAMPLE_PERIOD = fps_pkg::SAMPLE_PERIOD_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // config write port
  input  wire logic                             cfg_we,
  input  wire logic [fps_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [fps_pkg::CFG_DATA_W-1:0]   cfg_data,
  // sample channel
  input  wire logic                             in_valid,
  output      logic                             in_stall,
  input  wire fps_pkg::sample_t                 in_data,
  // result channel
  output      logic                             out_valid,
  input  wire logic                             out_stall,
  output      fps_pkg::result_t                 out_data
);

  // Residue of the staging count modulo SAMPLE_PERIOD is tracked alongside
  // the count, so the snapshot test needs no divider.
  localparam int unsigned RES_W     = $clog2(SAMPLE_PERIOD);
  localparam int unsigned SUM_DEPTH = SAMPLE_PERIOD + fps_pkg::TICKS_MAX;
  localparam int unsigned SUM_W     = $clog2(SUM_DEPTH);
  localparam int unsigned RES_SAT   = 65535 % SAMPLE_PERIOD;
  localparam int unsigned TICKS_W_L = fps_pkg::TICKS_W;

  // config registers
  logic signed [15:0] boost_trigger;
  logic signed [15:0] staging_trigger;
  logic [15:0]        main_altitude_agl;
  logic [15:0]        ground_level;
  logic [7:0]         separation_delay;

  // flight state
  fps_pkg::phase_t               phase, phase_next;
  logic [fps_pkg::COUNT_W-1:0]   count, count_next;
  logic [RES_W-1:0]              res, res_next;
  logic [15:0]                   ref_alt, ref_alt_next;
  logic [15:0]                   latest_alt, latest_alt_next;
  logic                          sep_latched, sep_latched_next;

  // input register
  logic             in_full;
  fps_pkg::sample_t in_q;
  logic             advance;

  // result register
  fps_pkg::result_t res_word;

  // step datapath
  logic                          entered;
  logic [TICKS_W_L-1:0]          add;
  logic [fps_pkg::COUNT_W:0]     sum_wide;
  logic [fps_pkg::COUNT_W-1:0]   cnt_base, cnt_new;
  logic [SUM_W-1:0]              res_sum;
  logic [RES_W-1:0]              res_base, res_new;
  logic signed [16:0]            agl_diff;

  // (r + ticks) mod SAMPLE_PERIOD, worked out at elaboration
  logic [RES_W-1:0] mod_tab [SUM_DEPTH];

  for (genvar g = 0; g < SUM_DEPTH; g++) begin : g_mod
    assign mod_tab[g] = RES_W'(g % SAMPLE_PERIOD);
  end

  // ---------------------------------------------------------------------
  // Handshake: the input register empties whenever the result register is
  // free or is being drained this cycle.
  // ---------------------------------------------------------------------
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign out_data = res_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      in_full   <= (in_valid && !in_stall) || (in_full && !advance);
      out_valid <= advance || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q <= in_data;
    end
    if (advance) begin
      res_word.flight_phase    <= phase_next;
      res_word.separation_fire <= sep_latched_next;
    end
  end

  // ---------------------------------------------------------------------
  // Config writes; unknown indexes are ignored.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      boost_trigger     <= '0;
      staging_trigger   <= '0;
      main_altitude_agl <= '0;
      ground_level      <= '0;
      separation_delay  <= fps_pkg::SEP_DELAY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fps_pkg::REG_BOOST_TRIGGER:     boost_trigger     <= $signed(cfg_data[15:0]);
        fps_pkg::REG_STAGING_TRIGGER:   staging_trigger   <= $signed(cfg_data[15:0]);
        fps_pkg::REG_MAIN_ALTITUDE_AGL: main_altitude_agl <= cfg_data[15:0];
        fps_pkg::REG_GROUND_LEVEL:      ground_level      <= cfg_data[15:0];
        fps_pkg::REG_SEPARATION_DELAY:  separation_delay  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // One flight step: transition rule first, then the staging rule on the
  // phase that results.
  // ---------------------------------------------------------------------
  assign agl_diff = $signed({1'b0, in_q.altitude}) - $signed({1'b0, ground_level});

  always_comb begin
    phase_next       = phase;
    count_next       = count;
    res_next         = res;
    ref_alt_next     = ref_alt;
    latest_alt_next  = latest_alt;
    sep_latched_next = sep_latched;
    entered          = 1'b0;

    unique case (phase)
      fps_pkg::PH_PAD: begin
        if (in_q.accel_axial > boost_trigger) phase_next = fps_pkg::PH_BOOST;
      end
      fps_pkg::PH_BOOST: begin
        if (in_q.accel_axial < staging_trigger) begin
          phase_next = fps_pkg::PH_STAGING;
          entered    = 1'b1;
        end
      end
      fps_pkg::PH_STAGING: begin
        if (sep_latched && (latest_alt < ref_alt)) phase_next = fps_pkg::PH_PARACHUTE;
      end
      fps_pkg::PH_PARACHUTE: begin
        if (agl_diff < $signed({1'b0, main_altitude_agl})) phase_next = fps_pkg::PH_GROUND;
      end
      default: ;
    endcase

    // entry sample starts the count at zero and adds nothing
    add      = entered ? '0 : in_q.half_ticks;
    cnt_base = entered ? '0 : count;
    res_base = entered ? '0 : res;
    sum_wide = {1'b0, cnt_base} + (fps_pkg::COUNT_W + 1)'(add);
    res_sum  = SUM_W'(res_base) + SUM_W'(add);
    if (sum_wide[fps_pkg::COUNT_W]) begin
      cnt_new = '1;
      res_new = RES_W'(RES_SAT);
    end else begin
      cnt_new = sum_wide[fps_pkg::COUNT_W-1:0];
      res_new = mod_tab[res_sum];
    end

    if (phase_next == fps_pkg::PH_STAGING) begin
      count_next = cnt_new;
      res_next   = res_new;
      if (cnt_new >= fps_pkg::COUNT_W'(separation_delay)) sep_latched_next = 1'b1;
      // altitude snapshot on every nonzero multiple of the period
      if ((cnt_new != '0) && (res_new == '0)) begin
        ref_alt_next    = latest_alt;
        latest_alt_next = in_q.altitude;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= fps_pkg::PH_PAD;
      count       <= '0;
      res         <= '0;
      ref_alt     <= '0;
      latest_alt  <= '0;
      sep_latched <= 1'b0;
    end else if (advance) begin
      phase       <= phase_next;
      count       <= count_next;
      res         <= res_next;
      ref_alt     <= ref_alt_next;
      latest_alt  <= latest_alt_next;
      sep_latched <= sep_latched_next;
    end
  end

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  `FPS_ASSERT_NXT(a_sep_sticky, sep_latched, sep_latched)
  `FPS_ASSERT_NXT(a_ground_final, phase == fps_pkg::PH_GROUND, phase == fps_pkg::PH_GROUND)
  `FPS_ASSERT_NXT(a_state_holds, !advance, $stable(phase) && $stable(count) && $stable(res))
  `FPS_ASSERT_IMP(a_res_range, 1'b1, {1'b0, res} < (RES_W + 1)'(SAMPLE_PERIOD))
  `FPS_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall)

endmodule

`default_nettype wire

// File: sim/fps_flight_check.sv
`default_nettype none

// Watches the sample, result and register write ports of the flight phase
// sequencer, predicts each result from its own copy of the state, and compares.
module fps_flight_check
  import fps_pkg::*;
#(
  parameter int unsigned SAMPLE_PERIOD = SAMPLE_PERIOD_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_valid,
  input  wire logic                   in_stall,
  input  wire sample_t                in_data,
  input  wire logic                   out_valid,
  input  wire logic                   out_stall,
  input  wire result_t                out_data,
  output int                          failures,
  output int                          pending,
  output int                          checked
);

  // register copies
  logic signed [15:0] boost_thr, stage_thr;
  logic [15:0]        main_agl, gnd_level;
  logic [7:0]         sep_delay;

  // flight state copy
  phase_t      phase_q;
  logic [15:0] stage_count, ref_alt, last_alt;
  logic        sep_fired;

  result_t expected_results[$];
  result_t want;

  initial begin
    failures = 0;
    pending  = 0;
    checked  = 0;
  end

  task automatic report(input string what, input int got, input int wanted);
    failures++;
    if (failures <= 40)
      $display("mismatch: %s got %0d expected %0d at %0t", what, got, wanted, $time);
  endtask

  // one sample: phase rule first, then the staging count, latch and snapshot
  function automatic result_t advance_flight(input sample_t s);
    logic               entering;
    logic [16:0]        sum;
    logic signed [17:0] height;
    result_t            r;
    entering = 1'b0;
    case (phase_q)
      PH_PAD: begin
        if ($signed(s.accel_axial) > boost_thr) phase_q = PH_BOOST;
      end
      PH_BOOST: begin
        if ($signed(s.accel_axial) < stage_thr) begin
          phase_q     = PH_STAGING;
          stage_count = '0;
          entering    = 1'b1;
        end
      end
      PH_STAGING: begin
        if (sep_fired && last_alt < ref_alt) phase_q = PH_PARACHUTE;
      end
      PH_PARACHUTE: begin
        height = $signed({2'b00, s.altitude}) - $signed({2'b00, gnd_level});
        if (height < $signed({2'b00, main_agl})) phase_q = PH_GROUND;
      end
      default: ;
    endcase
    if (phase_q == PH_STAGING) begin
      if (!entering) begin
        sum         = {1'b0, stage_count} + s.half_ticks;
        stage_count = sum[16] ? 16'hFFFF : sum[15:0];
      end
      if (stage_count >= sep_delay) sep_fired = 1'b1;
      if (stage_count != 0 && stage_count % SAMPLE_PERIOD == 0) begin
        ref_alt  = last_alt;
        last_alt = s.altitude;
      end
    end
    r.flight_phase    = phase_q;
    r.separation_fire = sep_fired;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      boost_thr   = '0;
      stage_thr   = '0;
      main_agl    = '0;
      gnd_level   = '0;
      sep_delay   = SEP_DELAY_RESET;
      phase_q     = PH_PAD;
      stage_count = '0;
      ref_alt     = '0;
      last_alt    = '0;
      sep_fired   = 1'b0;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report("result transfer with none outstanding", out_data, 0);
        end else begin
          want = expected_results.pop_front();
          checked++;
          if (out_data.flight_phase !== want.flight_phase)
            report("flight_phase", out_data.flight_phase, want.flight_phase);
          if (out_data.separation_fire !== want.separation_fire)
            report("separation_fire", out_data.separation_fire, want.separation_fire);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_BOOST_TRIGGER:     boost_thr = cfg_data;
          REG_STAGING_TRIGGER:   stage_thr = cfg_data;
          REG_MAIN_ALTITUDE_AGL: main_agl  = cfg_data;
          REG_GROUND_LEVEL:      gnd_level = cfg_data;
          REG_SEPARATION_DELAY:  sep_delay = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) expected_results.push_back(advance_flight(in_data));
    end
    pending = expected_results.size();
  end

endmodule

`default_nettype wire

// File: sim/tb.sv
`default_nettype none

// Top of the flight phase sequencer bench. Drives one flight per run (reset is
// applied only once, and ground is final), so the stimulus walks the phases in
// order: pad noise, boost noise, staging entry, the count and separation latch,
// then apogee, parachute and landing. The checker beside the block does all
// prediction and comparison; this module only stimulates and gives the verdict.
module tb;
  import fps_pkg::*;

  localparam int unsigned SHIFT = SAMPLE_PERIOD_DEF;
  // index that decodes to no register; writes to it must be ignored
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
  localparam int HOLD_CYCLES = 40;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_stall;
  sample_t                in_data;
  logic                   out_valid;
  logic                   out_stall;
  result_t                out_data;

  int failures, pending, checked;

  int sent;     // sample transfers accepted
  int staged;   // running half-second count since staging entry
  int alt_now;  // climbing altitude used while in staging
  bit no_gaps;  // sender offers back to back
  bit hold_off; // asks the receiver for one long stall

  flight_phase_sequencer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  fps_flight_check #(.SAMPLE_PERIOD(SAMPLE_PERIOD_DEF)) u_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .failures  (failures),
    .pending   (pending),
    .checked   (checked)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // generous cap: far above the slowest legal run
  initial begin
    #20000000;
    $display("tb: errors");
    $finish;
  end

  // mostly none or short, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  function automatic logic [15:0] rnd16();
    return 16'($urandom);
  endfunction

  // Receiver: random stall spans with calm stretches, plus one long hold-off
  // on request so the block backs up and stalls its sample input.
  initial begin
    int span_left;
    bit stalling;
    bit calm;
    out_stall = 1'b0;
    span_left = 0;
    stalling  = 1'b0;
    calm      = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        hold_off  = 1'b0;
        span_left = 0;
      end else begin
        if (span_left == 0) begin
          if ($urandom_range(0, 15) == 0) calm = !calm;
          span_left = 1 + pick_gap();
          stalling  = !calm && ($urandom_range(0, 2) == 0);
        end
        span_left--;
        out_stall <= stalling;
      end
    end
  end

  // One sample transfer. Entered and left just after a falling edge; valid
  // stays high into the next call unless a gap drops it.
  task automatic send(input logic signed [15:0] accel, input logic [15:0] alt,
                      input logic [TICKS_W-1:0] ticks);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= '{accel_axial: accel, altitude: alt, half_ticks: ticks};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent++;
  endtask

  // fully random samples, with back-to-back stretches switched on and off
  task automatic noise(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 24) == 0) no_gaps = !no_gaps;
      send(rnd16(), rnd16(), 4'($urandom));
    end
    no_gaps = 1'b0;
  endtask

  // staging sample with a non-falling altitude, so snapshots never show apogee
  task automatic climb(input int t);
    int step;
    step    = $urandom_range(0, 14);
    alt_now = (alt_now + step > 65535) ? 65535 : alt_now + step;
    staged  = (staged + t > 65535) ? 65535 : staged + t;
    send(rnd16(), 16'(alt_now), 4'(t));
  endtask

  // block idle: every result back, then a wait with the input idle for the pipeline
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int thr, g, m, delay_new;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = REG_BOOST_TRIGGER;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    no_gaps   = 1'b0;
    hold_off  = 1'b0;
    sent      = 0;
    staged    = 0;
    alt_now   = 0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Pad under reset registers (trigger 0): field extremes, none may launch.
    send(-16'sd32768, 16'h0000, 4'd0);
    send(16'sd0, 16'hFFFF, 4'd15);
    send(16'sd0, 16'h5555, 4'hA);
    settle();

    // Launch impossible: trigger at the signed maximum. Other registers get
    // extremes or junk; the delay write carries rubbish in its upper byte.
    cfg_write(REG_BOOST_TRIGGER, 16'h7FFF);
    cfg_write(REG_STAGING_TRIGGER, rnd16());
    cfg_write(REG_MAIN_ALTITUDE_AGL, 16'hFFFF);
    cfg_write(REG_GROUND_LEVEL, 16'hFFFF);
    cfg_write(REG_SEPARATION_DELAY, rnd16());
    cfg_write(REG_UNUSED, rnd16());
    send(16'sd32767, 16'hFFFF, 4'd15);   // equal to trigger: stays on the pad
    // long receiver hold-off while the sender keeps offering
    hold_off = 1'b1;
    no_gaps  = 1'b1;
    repeat (12) send(rnd16(), rnd16(), 4'($urandom));
    no_gaps = 1'b0;
    noise(150);
    settle();

    // Boost: launch on anything above the minimum, staging made impossible.
    cfg_write(REG_BOOST_TRIGGER, 16'h8000);
    cfg_write(REG_STAGING_TRIGGER, 16'h8000);
    send(-16'sd32768, rnd16(), 4'($urandom));     // not above: stays on the pad
    send(16'(int'($urandom_range(0, 65534)) - 32767), rnd16(), 4'($urandom));
    send(-16'sd32768, rnd16(), 4'($urandom));     // not below: stays in boost
    noise(120);
    settle();

    // Staging entry at a random threshold, separation delay at its maximum.
    thr = ($urandom_range(0, 3) == 0) ? 32767 : int'($urandom_range(0, 65534)) - 32767;
    cfg_write(REG_STAGING_TRIGGER, 16'(thr));
    cfg_write(REG_BOOST_TRIGGER, rnd16());
    cfg_write(REG_SEPARATION_DELAY, rnd16() | 16'h00FF);
    send(16'(thr), rnd16(), 4'($urandom));        // equal: stays in boost
    alt_now = $urandom_range(300, 2000);
    staged  = 0;
    send(16'(thr - 1), 16'(alt_now), 4'd15);      // entry sample adds no ticks

    // First snapshot at count 8, then the count held on a multiple: the
    // snapshot repeats. A falling pair here must not count as apogee, since
    // separation is not latched yet; a later rise restores the order.
    send(rnd16(), 16'(alt_now + 100), 4'(SHIFT));
    send(rnd16(), 16'(alt_now + 50), 4'd0);
    send(rnd16(), 16'(alt_now + 200), 4'd0);
    alt_now = alt_now + 200;
    staged  = SHIFT;
    while (staged < 100) climb($urandom_range(0, 15));
    settle();

    // Shorten the delay: either zero (fires on the next sample) or somewhere
    // ahead of the count up to 255, so the latch comes at the compare boundary.
    if ($urandom_range(0, 1) == 0) delay_new = 0;
    else delay_new = $urandom_range(staged + 1, 255);
    cfg_write(REG_SEPARATION_DELAY, (rnd16() & 16'hFF00) | 16'(delay_new));
    for (int i = 0; i < 40 || staged < 300; i++) climb($urandom_range(0, 15));

    // Apogee: land the count on a snapshot multiple, then a lower altitude.
    climb((staged % SHIFT == 0) ? SHIFT : SHIFT - staged % SHIFT);
    send(rnd16(), 16'(alt_now - 1 - $urandom_range(0, alt_now - 1)), 4'(SHIFT));
    settle();
    // Parachute held open: height above ground is never negative.
    cfg_write(REG_MAIN_ALTITUDE_AGL, 16'h0000);
    cfg_write(REG_GROUND_LEVEL, 16'h0000);
    noise(100);
    settle();
    if ($urandom_range(0, 1) == 0) begin
      // below ground level: a negative height always lands
      g = $urandom_range(1, 65535);
      cfg_write(REG_GROUND_LEVEL, 16'(g));
      send(rnd16(), 16'(g), 4'($urandom));
      repeat (20) send(rnd16(), 16'($urandom_range(g, 65535)), 4'($urandom));
      send(rnd16(), 16'($urandom_range(0, g - 1)), 4'($urandom));
    end else begin
      m = $urandom_range(1, 30000);
      g = $urandom_range(0, 30000);
      cfg_write(REG_MAIN_ALTITUDE_AGL, 16'(m));
      cfg_write(REG_GROUND_LEVEL, 16'(g));
      send(rnd16(), 16'(g + m), 4'($urandom));
      repeat (20) send(rnd16(), 16'($urandom_range(g + m, 65535)), 4'($urandom));
      send(rnd16(), 16'(g + m - 1), 4'($urandom));
    end
    settle();
    // ground is final whatever the registers say
    cfg_write(REG_BOOST_TRIGGER, 16'h8000);
    cfg_write(REG_STAGING_TRIGGER, 16'h7FFF);
    cfg_write(REG_MAIN_ALTITUDE_AGL, 16'hFFFF);
    cfg_write(REG_GROUND_LEVEL, 16'h0000);
    cfg_write(REG_SEPARATION_DELAY, 16'h0000);
    noise(150);

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    $display("summary: %0d samples, %0d results compared", sent, checked);
    $display("summary: one flight from pad through staging and apogee to landing");
    if (failures == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
+incdir+rtl
rtl/fps_pkg.sv
rtl/flight_phase_sequencer_unit.sv
sim/fps_flight_check.sv
sim/tb.sv
